[rtl/pkvsar_pkg.sv]
// shared types, codes and constants of the paged kv address resolver
`timescale 1ns / 1ps

package pkvsar_pkg;

  localparam int BatchesDefault   = 64;
  localparam int MaxBlocksDefault = 256;

  localparam int BlkShift      = 7;
  localparam int CfgIdxW       = 3;
  localparam int CfgDataW      = 32;
  localparam int RowW          = 38;

  // item kinds
  localparam logic [1:0] KIND_LOAD_SRC = 2'd0;
  localparam logic [1:0] KIND_LOAD_DST = 2'd1;
  localparam logic [1:0] KIND_LOAD_CNT = 2'd2;
  localparam logic [1:0] KIND_RESOLVE  = 2'd3;

  // result status codes
  localparam logic [2:0] ST_COPY      = 3'd0;
  localparam logic [2:0] ST_LOAD_DONE = 3'd1;
  localparam logic [2:0] ST_BEYOND    = 3'd2;
  localparam logic [2:0] ST_NEG_ID    = 3'd3;
  localparam logic [2:0] ST_COL_RANGE = 3'd4;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd5;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_COPY_CAP  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SRC_COLS  = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DST_COLS  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SRC_PHYS  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_DST_PHYS  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_ROPE_MODE = 3'd5;

  typedef struct packed {
    logic [1:0]         kind;
    logic [5:0]         batch;
    logic [7:0]         column;
    logic signed [31:0] value;
    logic [15:0]        pair_index;
    logic signed [31:0] src_token;
    logic signed [31:0] dst_token;
  } item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [47:0] src_kv_addr;
    logic [47:0] dst_kv_addr;
    logic [44:0] src_rope_addr;
    logic [44:0] dst_rope_addr;
  } result_t;

endpackage

[rtl/pkvsar_ram.sv]
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps

module pkvsar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/paged_kv_scatter_address_resolver.sv]
// paged kv block table resolver: table loads and copy address generation
// a result passes the stage 1 registers, the stage 2 registers and the output register before it strobes
// throughput: one item per cycle, every item answers once; busy stays low
// the result side cannot stall, so the pipeline never holds back an item
// reset clears pipeline valids and returns config registers to their defaults;
// tables and counts are undefined until loaded
`timescale 1ns / 1ps

module paged_kv_scatter_address_resolver
  import pkvsar_pkg::*;
#(
  parameter int BATCHES    = BatchesDefault,
  parameter int MAX_BLOCKS = MaxBlocksDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  item_t               item_i,
  output logic                res_valid_o,
  output result_t             res_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  localparam int TblDepth = BATCHES * MAX_BLOCKS;
  localparam int TblAw    = (TblDepth > 1) ? $clog2(TblDepth) : 1;
  localparam int CntAw    = (BATCHES > 1) ? $clog2(BATCHES) : 1;

  // configuration registers
  logic [15:0] copy_cap_q;
  logic [8:0]  src_cols_q, dst_cols_q;
  logic [30:0] src_phys_q, dst_phys_q;
  logic        rope_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      copy_cap_q <= 16'd1;
      src_cols_q <= 9'd256;
      dst_cols_q <= 9'd256;
      src_phys_q <= '0;
      dst_phys_q <= '0;
      rope_q     <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_COPY_CAP:  copy_cap_q <= cfg_data_i[15:0];
        REG_SRC_COLS:  src_cols_q <= cfg_data_i[8:0];
        REG_DST_COLS:  dst_cols_q <= cfg_data_i[8:0];
        REG_SRC_PHYS:  src_phys_q <= cfg_data_i[30:0];
        REG_DST_PHYS:  dst_phys_q <= cfg_data_i[30:0];
        REG_ROPE_MODE: rope_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // stage 0: accept, write loads, issue table reads for resolves
  logic        accept;
  logic        batch_in, column_in, is_resolve;
  logic [31:0] tbl_base;
  logic [24:0] scol, dcol;
  logic        col_ok;
  logic        src_we, dst_we, cnt_we;
  logic [TblAw-1:0] ld_addr, src_raddr, dst_raddr;
  logic [CntAw-1:0] cnt_addr;
  logic [31:0] src_entry, dst_entry, cnt_entry;

  assign accept     = start && !busy;
  assign is_resolve = (item_i.kind == KIND_RESOLVE);
  assign batch_in   = 32'(item_i.batch) < 32'(BATCHES);
  assign column_in  = 32'(item_i.column) < 32'(MAX_BLOCKS);
  assign tbl_base   = 32'(item_i.batch) * 32'(MAX_BLOCKS);
  assign scol       = item_i.src_token[31:BlkShift];
  assign dcol       = item_i.dst_token[31:BlkShift];
  assign col_ok     = (32'(scol) < 32'(src_cols_q)) && (32'(scol) < 32'(MAX_BLOCKS)) &&
                      (32'(dcol) < 32'(dst_cols_q)) && (32'(dcol) < 32'(MAX_BLOCKS));

  assign ld_addr   = TblAw'(tbl_base + 32'(item_i.column));
  assign src_raddr = TblAw'(tbl_base + 32'(scol));
  assign dst_raddr = TblAw'(tbl_base + 32'(dcol));
  assign cnt_addr  = CntAw'(item_i.batch);

  assign src_we = accept && (item_i.kind == KIND_LOAD_SRC) && batch_in && column_in;
  assign dst_we = accept && (item_i.kind == KIND_LOAD_DST) && batch_in && column_in;
  assign cnt_we = accept && (item_i.kind == KIND_LOAD_CNT) && batch_in;

  // loads write at their own accept edge, so a resolve in the next cycle reads new data
  pkvsar_ram #(.WIDTH(32), .DEPTH(TblDepth), .AW(TblAw)) u_src_tbl (
    .clk_i,
    .wr_en_i   (src_we),
    .wr_addr_i (ld_addr),
    .wr_data_i (item_i.value),
    .rd_en_i   (accept && is_resolve),
    .rd_addr_i (src_raddr),
    .rd_data_o (src_entry)
  );

  pkvsar_ram #(.WIDTH(32), .DEPTH(TblDepth), .AW(TblAw)) u_dst_tbl (
    .clk_i,
    .wr_en_i   (dst_we),
    .wr_addr_i (ld_addr),
    .wr_data_i (item_i.value),
    .rd_en_i   (accept && is_resolve),
    .rd_addr_i (dst_raddr),
    .rd_data_o (dst_entry)
  );

  pkvsar_ram #(.WIDTH(32), .DEPTH(BATCHES), .AW(CntAw)) u_cnt (
    .clk_i,
    .wr_en_i   (cnt_we),
    .wr_addr_i (cnt_addr),
    .wr_data_i (item_i.value),
    .rd_en_i   (accept && is_resolve),
    .rd_addr_i (cnt_addr),
    .rd_data_o (cnt_entry)
  );

  // stage 1 registers, alongside the ram read
  logic        s1_valid_q;
  logic        s1_resolve_q, s1_bin_q, s1_neg_q, s1_col_ok_q;
  logic [15:0] s1_pidx_q;
  logic [6:0]  s1_slo_q, s1_dlo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_resolve_q <= is_resolve;
      s1_bin_q     <= batch_in;
      s1_neg_q     <= item_i.src_token[31] || item_i.dst_token[31];
      s1_col_ok_q  <= col_ok;
      s1_pidx_q    <= item_i.pair_index;
      s1_slo_q     <= item_i.src_token[BlkShift-1:0];
      s1_dlo_q     <= item_i.dst_token[BlkShift-1:0];
    end
  end

  // stage 1 checks on the read data
  logic       beyond, blk_ok;
  logic [2:0] s2_status_d;

  // clamped count: negative means zero, otherwise min(count, copy_cap)
  assign beyond = cnt_entry[31] || (32'(s1_pidx_q) >= cnt_entry) ||
                  (s1_pidx_q >= copy_cap_q);
  assign blk_ok = !src_entry[31] && (src_entry[30:0] < src_phys_q) &&
                  !dst_entry[31] && (dst_entry[30:0] < dst_phys_q);

  always_comb begin
    if (!s1_resolve_q) begin
      s2_status_d = ST_LOAD_DONE;
    end else if (!s1_bin_q || beyond) begin
      s2_status_d = ST_BEYOND;
    end else if (s1_neg_q) begin
      s2_status_d = ST_NEG_ID;
    end else if (!s1_col_ok_q) begin
      s2_status_d = ST_COL_RANGE;
    end else if (!blk_ok) begin
      s2_status_d = ST_BAD_BLOCK;
    end else begin
      s2_status_d = ST_COPY;
    end
  end

  // stage 2 registers
  logic            s2_valid_q;
  logic [2:0]      s2_status_q;
  logic [RowW-1:0] s2_srow_q, s2_drow_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_status_q <= s2_status_d;
      s2_srow_q   <= {src_entry[30:0], s1_slo_q};
      s2_drow_q   <= {dst_entry[30:0], s1_dlo_q};
    end
  end

  // stage 2: row to byte address, 1024 or 656 (512 + 128 + 16) bytes per row
  result_t res_d;
  logic    copy;

  assign copy = (s2_status_q == ST_COPY);

  always_comb begin
    res_d        = '0;
    res_d.status = s2_status_q;
    if (copy) begin
      if (rope_q) begin
        res_d.src_kv_addr   = {s2_srow_q, 10'd0};
        res_d.dst_kv_addr   = {s2_drow_q, 10'd0};
        res_d.src_rope_addr = {s2_srow_q, 7'd0};
        res_d.dst_rope_addr = {s2_drow_q, 7'd0};
      end else begin
        res_d.src_kv_addr = 48'({s2_srow_q, 9'd0}) + 48'({s2_srow_q, 7'd0}) +
                            48'({s2_srow_q, 4'd0});
        res_d.dst_kv_addr = 48'({s2_drow_q, 9'd0}) + 48'({s2_drow_q, 7'd0}) +
                            48'({s2_drow_q, 4'd0});
      end
    end
  end

  // output register
  logic    res_valid_q;
  result_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_valid_q) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule
